// ----- rtl/tms_pkg.sv -----
// Shared types, codes and constants of the temperature mode supervisor.
package tms_pkg;

	localparam int TEMP_W     = 12;
	localparam int HUM_W      = 12;
	localparam int HYST_W     = 8;
	localparam int LIMIT_W    = 8;
	localparam int FAIL_W     = 16;
	localparam int PHASE_W    = 8;
	localparam int MODE_W     = 2;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int WIDE_W     = 14;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic signed [HUM_W-1:0]  hum_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic [HYST_W-1:0]        hyst_t;
	typedef logic [LIMIT_W-1:0]       limit_t;
	typedef logic [FAIL_W-1:0]        fail_t;
	typedef logic [PHASE_W-1:0]       phase_t;
	typedef logic [MODE_W-1:0]        mode_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

	localparam mode_t MODE_NORMAL = 2'd0;
	localparam mode_t MODE_COLD   = 2'd1;
	localparam mode_t MODE_HOT    = 2'd2;
	localparam mode_t MODE_ERROR  = 2'd3;

	localparam cfg_idx_t REG_COLD_THRESHOLD = 3'd0;
	localparam cfg_idx_t REG_HOT_THRESHOLD  = 3'd1;
	localparam cfg_idx_t REG_HYSTERESIS     = 3'd2;
	localparam cfg_idx_t REG_FAIL_LIMIT     = 3'd3;
	localparam cfg_idx_t REG_ALARM_TEMP     = 3'd4;

	localparam temp_t  COLD_RESET  = 12'sd180;
	localparam temp_t  HOT_RESET   = 12'sd320;
	localparam hyst_t  HYST_RESET  = 8'd10;
	localparam limit_t LIMIT_RESET = 8'd3;
	localparam temp_t  ALARM_RESET = 12'sd350;

	// Plausible sensor range; anything outside is treated as a failed read.
	localparam temp_t T_MIN = -12'sd400;
	localparam temp_t T_MAX = 12'sd1250;
	localparam hum_t  H_MIN = 12'sd0;
	localparam hum_t  H_MAX = 12'sd1000;

	localparam fail_t FAIL_SAT = '1;

	typedef struct packed {
		temp_t  cold_threshold;
		temp_t  hot_threshold;
		hyst_t  hysteresis;
		limit_t fail_limit;
		temp_t  alarm_temp;
	} cfg_t;

	typedef struct packed {
		logic  read_ok;
		temp_t temperature;
		hum_t  humidity;
	} sample_t;

	typedef struct packed {
		mode_t  mode;
		fail_t  fails;
		phase_t phase;
		logic   alarm_latched;
	} state_t;

	typedef struct packed {
		mode_t mode;
		logic  mode_changed;
		logic  hot_alarm;
		logic  bus_reset;
		logic  reading_valid;
		fail_t failures;
	} result_t;

endpackage

// ----- rtl/tms_sample_if.sv -----
// Request channel carrying one sensor reading.
interface tms_sample_if;
	logic              valid;
	logic              ready;
	logic              read_ok;
	tms_pkg::temp_t    temperature;
	tms_pkg::hum_t     humidity;

	modport source (output valid, output read_ok, output temperature, output humidity,
		input ready);
	modport sink (input valid, input read_ok, input temperature, input humidity,
		output ready);
endinterface

// ----- rtl/tms_result_if.sv -----
// Request channel carrying one supervisor result.
interface tms_result_if;
	logic              valid;
	logic              ready;
	tms_pkg::mode_t    mode;
	logic              mode_changed;
	logic              hot_alarm;
	logic              bus_reset;
	logic              reading_valid;
	tms_pkg::fail_t    failures;

	modport source (output valid, output mode, output mode_changed, output hot_alarm,
		output bus_reset, output reading_valid, output failures, input ready);
	modport sink (input valid, input mode, input mode_changed, input hot_alarm,
		input bus_reset, input reading_valid, input failures, output ready);
endinterface

// ----- rtl/temperature_mode_supervisor.sv -----
// Top level of the temperature mode supervisor.
//
//   channel   direction  carries
//   sample    in         read_ok, temperature, humidity
//   result    out        mode, mode_changed, hot_alarm, bus_reset, reading_valid, failures
//   cfg_*     in         register writes, index 0..4
//
// A request passes from acceptance through the input register and then the result register
// before its result is shown. One request is accepted every cycle when result is drained.
// The mode state updates in the same edge that loads the result register.
// Reset clears the mode state and the valid flags and loads the register reset values.
// A stalled result holds the input register; the sample channel stalls once it is full.
module temperature_mode_supervisor (
	input  logic               clk,
	input  logic               arst_n,
	tms_sample_if.sink         sample,
	tms_result_if.source       result,
	input  logic               cfg_we,
	input  tms_pkg::cfg_idx_t  cfg_index,
	input  tms_pkg::cfg_data_t cfg_data
);
	import tms_pkg::*;

	cfg_t    cfg;
	sample_t sample_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    res_valid_q;
	logic    advance;

	tms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tms_step u_step (
		.sample (sample_s1),
		.cur    (state_q),
		.cfg    (cfg),
		.nxt    (state_nxt),
		.res    (res_nxt)
	);

	assign advance = valid_s1 && (!res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_s1.read_ok     <= sample.read_ok;
			sample_s1.temperature <= sample.temperature;
			sample_s1.humidity    <= sample.humidity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode          <= MODE_NORMAL;
			state_q.fails         <= '0;
			state_q.phase         <= '0;
			state_q.alarm_latched <= 1'b0;
			res_valid_q           <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.mode          = res_q.mode;
	assign result.mode_changed  = res_q.mode_changed;
	assign result.hot_alarm     = res_q.hot_alarm;
	assign result.bus_reset     = res_q.bus_reset;
	assign result.reading_valid = res_q.reading_valid;
	assign result.failures      = res_q.failures;

	// The result register always reflects the most recent state update.
	a_mode_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.mode == state_q.mode && result.failures == state_q.fails))
		else $error("result mode or count differs from state");

	// The bus reset phase restarts with the failure count and can never pass it.
	a_phase_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fail_t'(state_q.phase) <= state_q.fails)
		else $error("bus reset phase exceeds failure count");

	// A good reading always clears the failure count.
	a_good_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_nxt.reading_valid) |=> (state_q.fails == '0 && state_q.phase == '0))
		else $error("good reading left failures pending");

	// A delivered hot alarm leaves the alarm latched.
	a_alarm_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.hot_alarm) |-> state_q.alarm_latched)
		else $error("hot alarm without latch");
endmodule

// ----- rtl/tms_cfg.sv -----
// Configuration register bank of the temperature mode supervisor.
module tms_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  tms_pkg::cfg_idx_t  cfg_index,
	input  tms_pkg::cfg_data_t cfg_data,
	output tms_pkg::cfg_t      cfg
);
	import tms_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cold_threshold <= COLD_RESET;
			cfg_q.hot_threshold  <= HOT_RESET;
			cfg_q.hysteresis     <= HYST_RESET;
			cfg_q.fail_limit     <= LIMIT_RESET;
			cfg_q.alarm_temp     <= ALARM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLD_THRESHOLD: cfg_q.cold_threshold <= temp_t'(cfg_data[TEMP_W-1:0]);
				REG_HOT_THRESHOLD:  cfg_q.hot_threshold  <= temp_t'(cfg_data[TEMP_W-1:0]);
				REG_HYSTERESIS:     cfg_q.hysteresis     <= cfg_data[HYST_W-1:0];
				REG_FAIL_LIMIT:     cfg_q.fail_limit     <= cfg_data[LIMIT_W-1:0];
				REG_ALARM_TEMP:     cfg_q.alarm_temp     <= temp_t'(cfg_data[TEMP_W-1:0]);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ----- rtl/tms_step.sv -----
// Next-state and result logic for one reading.
module tms_step (
	input  tms_pkg::sample_t sample,
	input  tms_pkg::state_t  cur,
	input  tms_pkg::cfg_t    cfg,
	output tms_pkg::state_t  nxt,
	output tms_pkg::result_t res
);
	import tms_pkg::*;

	logic   good;
	limit_t limit;
	fail_t  fails_inc;
	phase_t phase_inc;
	wide_t  t_w;
	wide_t  leave_cold;
	wide_t  leave_hot;
	mode_t  next_mode;
	logic   latched;

	always_comb begin
		good = sample.read_ok
			&& (sample.temperature >= T_MIN) && (sample.temperature <= T_MAX)
			&& (sample.humidity >= H_MIN) && (sample.humidity <= H_MAX);
		limit = (cfg.fail_limit == '0) ? limit_t'(1) : cfg.fail_limit;
		fails_inc = (cur.fails == FAIL_SAT) ? cur.fails : cur.fails + fail_t'(1);
		phase_inc = cur.phase + phase_t'(1);
		t_w = wide_t'(sample.temperature);
		leave_cold = wide_t'(cfg.cold_threshold) + $signed({{(WIDE_W-HYST_W){1'b0}}, cfg.hysteresis});
		leave_hot = wide_t'(cfg.hot_threshold) - $signed({{(WIDE_W-HYST_W){1'b0}}, cfg.hysteresis});
		next_mode = cur.mode;
		latched = cur.alarm_latched;

		nxt = cur;
		res.mode = cur.mode;
		res.mode_changed = 1'b0;
		res.hot_alarm = 1'b0;
		res.bus_reset = 1'b0;
		res.reading_valid = good;
		res.failures = '0;

		if (!good) begin
			nxt.fails = fails_inc;
			nxt.phase = phase_inc;
			if (fails_inc >= fail_t'(limit) && cur.mode != MODE_ERROR) begin
				nxt.mode = MODE_ERROR;
				res.mode_changed = 1'b1;
			end
			if (phase_inc >= phase_t'(limit)) begin
				nxt.phase = '0;
				res.bus_reset = 1'b1;
			end
		end else begin
			nxt.fails = '0;
			nxt.phase = '0;
			case (cur.mode)
				MODE_ERROR: next_mode = MODE_NORMAL;
				MODE_NORMAL: begin
					if (sample.temperature < cfg.cold_threshold) next_mode = MODE_COLD;
					if (sample.temperature > cfg.hot_threshold) next_mode = MODE_HOT;
				end
				MODE_COLD: begin
					if (t_w >= leave_cold) next_mode = MODE_NORMAL;
					if (sample.temperature > cfg.hot_threshold) next_mode = MODE_HOT;
				end
				default: begin
					if (t_w <= leave_hot) next_mode = MODE_NORMAL;
					if (sample.temperature < cfg.cold_threshold) next_mode = MODE_COLD;
				end
			endcase
			if (next_mode != cur.mode) begin
				res.mode_changed = 1'b1;
				latched = 1'b0;
			end
			// The alarm fires once per excursion, judged on the mode before this step.
			if (cur.mode == MODE_HOT && sample.temperature > cfg.alarm_temp && !latched) begin
				res.hot_alarm = 1'b1;
				latched = 1'b1;
			end
			if (sample.temperature <= cfg.alarm_temp) latched = 1'b0;
			nxt.mode = next_mode;
			nxt.alarm_latched = latched;
		end

		res.mode = nxt.mode;
		res.failures = nxt.fails;
	end
endmodule

// ----- tb/sv/tms_checker.sv -----
// Scoreboard that predicts every supervisor result and compares it with the block's output.
module tms_checker (
	input  logic               clk,
	input  logic               arst_n,
	tms_sample_if              sample,
	tms_result_if              result,
	input  logic               cfg_we,
	input  tms_pkg::cfg_idx_t  cfg_index,
	input  tms_pkg::cfg_data_t cfg_data,
	output int                 errors,
	output int                 outstanding
);
	import tms_pkg::*;

	cfg_t    regs;
	mode_t   mode_q;
	fail_t   fail_cnt;
	phase_t  phase_cnt;
	logic    alarm_sent;
	result_t expected_q [$];
	int      mism = 0;
	int      pend = 0;

	assign errors      = mism;
	assign outstanding = pend;

	// Advances the supervisor state by one reading and returns the result it gives.
	function automatic result_t supervise(logic ok, temp_t temp, hum_t hum);
		result_t r;
		int      t, h, limit, cold, hot, hy, alt;
		logic    good;
		mode_t   prev, nxt;
		t     = int'(temp);
		h     = int'(hum);
		limit = (regs.fail_limit == 0) ? 1 : int'(regs.fail_limit);
		prev  = mode_q;
		r     = '0;
		good  = ok && t >= int'(T_MIN) && t <= int'(T_MAX)
			&& h >= int'(H_MIN) && h <= int'(H_MAX);
		if (!good) begin
			if (fail_cnt != FAIL_SAT)
				fail_cnt++;
			phase_cnt++;
			if (int'(fail_cnt) >= limit && mode_q != MODE_ERROR) begin
				mode_q         = MODE_ERROR;
				r.mode_changed = 1'b1;
			end
			if (int'(phase_cnt) >= limit) begin
				phase_cnt   = '0;
				r.bus_reset = 1'b1;
			end
		end else begin
			cold      = int'($signed(regs.cold_threshold));
			hot       = int'($signed(regs.hot_threshold));
			hy        = int'(regs.hysteresis);
			alt       = int'($signed(regs.alarm_temp));
			fail_cnt  = '0;
			phase_cnt = '0;
			nxt       = prev;
			case (prev)
				MODE_ERROR: nxt = MODE_NORMAL;
				MODE_NORMAL: begin
					if (t < cold) nxt = MODE_COLD;
					if (t > hot) nxt = MODE_HOT;
				end
				MODE_COLD: begin
					if (t >= cold + hy) nxt = MODE_NORMAL;
					if (t > hot) nxt = MODE_HOT;
				end
				default: begin
					if (t <= hot - hy) nxt = MODE_NORMAL;
					if (t < cold) nxt = MODE_COLD;
				end
			endcase
			if (nxt != prev) begin
				mode_q         = nxt;
				r.mode_changed = 1'b1;
				alarm_sent     = 1'b0;
			end
			if (prev == MODE_HOT && t > alt && !alarm_sent) begin
				r.hot_alarm = 1'b1;
				alarm_sent  = 1'b1;
			end
			if (t <= alt)
				alarm_sent = 1'b0;
			r.reading_valid = 1'b1;
		end
		r.mode     = mode_q;
		r.failures = fail_cnt;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want, got;
		if (!arst_n) begin
			regs       = '{COLD_RESET, HOT_RESET, HYST_RESET, LIMIT_RESET, ALARM_RESET};
			mode_q     = MODE_NORMAL;
			fail_cnt   = '0;
			phase_cnt  = '0;
			alarm_sent = 1'b0;
			expected_q.delete();
			pend <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COLD_THRESHOLD: regs.cold_threshold = cfg_data[TEMP_W-1:0];
					REG_HOT_THRESHOLD:  regs.hot_threshold  = cfg_data[TEMP_W-1:0];
					REG_HYSTERESIS:     regs.hysteresis     = cfg_data[HYST_W-1:0];
					REG_FAIL_LIMIT:     regs.fail_limit     = cfg_data[LIMIT_W-1:0];
					REG_ALARM_TEMP:     regs.alarm_temp     = cfg_data[TEMP_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				got = '{result.mode, result.mode_changed, result.hot_alarm, result.bus_reset,
					result.reading_valid, result.failures};
				if (expected_q.size() == 0) begin
					if (mism < 10)
						$display("%0t: result with no reading pending: mode=%0d fails=%0d",
							$time, got.mode, got.failures);
					mism++;
				end else begin
					want = expected_q.pop_front();
					if (got.mode !== want.mode || got.mode_changed !== want.mode_changed ||
						got.hot_alarm !== want.hot_alarm || got.bus_reset !== want.bus_reset ||
						got.reading_valid !== want.reading_valid ||
						got.failures !== want.failures) begin
						if (mism < 10) begin
							$display("%0t: expected mode=%0d chg=%0b alm=%0b bus=%0b val=%0b f=%0d",
								$time, want.mode, want.mode_changed, want.hot_alarm,
								want.bus_reset, want.reading_valid, want.failures);
							$display("%0t: actual   mode=%0d chg=%0b alm=%0b bus=%0b val=%0b f=%0d",
								$time, got.mode, got.mode_changed, got.hot_alarm,
								got.bus_reset, got.reading_valid, got.failures);
						end
						mism++;
					end
				end
			end
			if (sample.valid && sample.ready)
				expected_q.push_back(supervise(sample.read_ok, sample.temperature,
					sample.humidity));
			pend <= expected_q.size();
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the supervisor testbench: clock, reset, register writes, readings and the verdict.
module testbench;
	import tms_pkg::*;

	localparam int RANDOM_ITEMS = 1800;
	localparam int PHASES       = 8;
	localparam int HOLD_CYCLES  = 200;
	localparam int WATCHDOG     = 2000;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_data;
	int        errors;
	int        outstanding;
	int        idle_cycles = 0;
	int        fed         = 0;
	int        burst_left  = 0;
	bit        pressure_done = 1'b0;
	cfg_t      cur;

	tms_sample_if sample ();
	tms_result_if result ();

	temperature_mode_supervisor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tms_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (sample.valid && sample.ready) || (result.valid && result.ready)
			|| cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (arst_n && sample.valid && sample.ready)
			fed <= fed + 1;
	end

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		int   lo, hi;
		if ($urandom_range(0, 3) == 0) begin
			c.cold_threshold = temp_t'($urandom);
			c.hot_threshold  = temp_t'($urandom);
			c.hysteresis     = hyst_t'($urandom);
			c.fail_limit     = limit_t'($urandom);
			c.alarm_temp     = temp_t'($urandom);
		end else begin
			lo = $urandom_range(0, 1500);
			lo -= 400;
			hi = lo + $urandom_range(0, 400);
			if (hi > int'(T_MAX)) hi = int'(T_MAX);
			c.cold_threshold = temp_t'(lo);
			c.hot_threshold  = temp_t'(hi);
			c.hysteresis     = hyst_t'($urandom_range(0, 200));
			c.fail_limit     = limit_t'($urandom_range(1, 12));
			hi = hi + $urandom_range(0, 200) - 50;
			if (hi > int'(T_MAX)) hi = int'(T_MAX);
			c.alarm_temp = temp_t'(hi);
		end
		return c;
	endfunction

	task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// The 8-bit registers get random upper bits, which the block must ignore.
	task automatic load_config(cfg_t c);
		logic [3:0] pad;
		cur = c;
		write_reg(REG_COLD_THRESHOLD, c.cold_threshold);
		write_reg(REG_HOT_THRESHOLD, c.hot_threshold);
		pad = 4'($urandom);
		write_reg(REG_HYSTERESIS, {pad, c.hysteresis});
		pad = 4'($urandom);
		write_reg(REG_FAIL_LIMIT, {pad, c.fail_limit});
		write_reg(REG_ALARM_TEMP, c.alarm_temp);
		cfg_we <= 1'b0;
	endtask

	task automatic push_reading(logic ok, int t, int h, bit gaps);
		int g;
		g = gaps ? pause_len() : 0;
		if (g > 0) begin
			sample.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		sample.valid       <= 1'b1;
		sample.read_ok     <= ok;
		sample.temperature <= temp_t'(t);
		sample.humidity    <= hum_t'(h);
		do @(posedge clk); while (sample.ready !== 1'b1);
	endtask

	// Drops the request and waits until every result has been taken.
	task automatic settle();
		sample.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Mostly plausible readings near the thresholds, with failure bursts and raw noise.
	task automatic random_reading(bit gaps);
		int   r, t, h, anchor, off, lim;
		logic ok;
		lim = (cur.fail_limit == 0) ? 1 : int'(cur.fail_limit);
		if (burst_left == 0 && $urandom_range(0, 39) == 0)
			burst_left = $urandom_range(1, lim + 2);
		r = $urandom_range(0, 99);
		if (burst_left > 0 || r < 10) begin
			if (burst_left > 0)
				burst_left--;
			ok = 1'b1;
			t  = $urandom_range(0, 1650);
			t -= 400;
			h  = $urandom_range(0, 1000);
			case ($urandom_range(0, 3))
				0: begin
					ok = 1'b0;
					t  = $urandom;
					h  = $urandom;
				end
				1: t = $urandom_range(0, 1) ? int'($urandom_range(1251, 2047))
					: -int'($urandom_range(401, 2048));
				2: h = $urandom_range(0, 1) ? int'($urandom_range(1001, 2047))
					: -int'($urandom_range(1, 2048));
				default: ok = 1'b0;
			endcase
		end else if (r < 18) begin
			ok = 1'($urandom);
			t  = $urandom;
			h  = $urandom;
		end else begin
			ok = 1'b1;
			h  = $urandom_range(0, 1000);
			case ($urandom_range(0, 6))
				0: anchor = int'($signed(cur.cold_threshold));
				1: anchor = int'($signed(cur.cold_threshold)) + int'(cur.hysteresis);
				2: anchor = int'($signed(cur.hot_threshold));
				3: anchor = int'($signed(cur.hot_threshold)) - int'(cur.hysteresis);
				4: anchor = int'($signed(cur.alarm_temp));
				5: anchor = int'(T_MIN);
				default: anchor = int'(T_MAX);
			endcase
			if ($urandom_range(0, 3) == 0) begin
				off = $urandom_range(0, 120);
				off -= 60;
			end else begin
				off = $urandom_range(0, 6);
				off -= 3;
			end
			t = anchor + off;
			if (t < int'(T_MIN)) t = int'(T_MIN);
			if (t > int'(T_MAX)) t = int'(T_MAX);
		end
		push_reading(ok, t, h, gaps);
	endtask

	// Receiver side: one long hold-off early on, then random stalls and clean stretches.
	initial begin
		int stall;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!pressure_done && fed >= 64) begin
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				pressure_done = 1'b1;
			end else if ($urandom_range(0, 4) == 0) begin
				result.ready <= 1'b1;
				repeat ($urandom_range(30, 150)) @(posedge clk);
			end else begin
				stall = pause_len();
				if (stall > 0) begin
					result.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				result.ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	initial begin
		cfg_t plan [4];
		int   p, i;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= REG_COLD_THRESHOLD;
		cfg_data           <= '0;
		sample.valid       <= 1'b0;
		sample.read_ok     <= 1'b0;
		sample.temperature <= '0;
		sample.humidity    <= '0;
		cur = '{COLD_RESET, HOT_RESET, HYST_RESET, LIMIT_RESET, ALARM_RESET};
		plan[0] = '{temp_t'(-400), temp_t'(1250), hyst_t'(0), limit_t'(0), temp_t'(-400)};
		plan[1] = '{temp_t'(1250), temp_t'(-400), hyst_t'(200), limit_t'(255), temp_t'(1250)};
		plan[2] = '{COLD_RESET, HOT_RESET, HYST_RESET, LIMIT_RESET, ALARM_RESET};
		plan[3] = '{temp_t'(-2048), temp_t'(2047), hyst_t'(255), limit_t'(1), temp_t'(2047)};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Mode walk with hysteresis and the one-shot alarm under the reset settings.
		push_reading(1'b1, 250, 500, 1'b1);
		push_reading(1'b1, 179, 500, 1'b1);
		push_reading(1'b1, 189, 0, 1'b1);
		push_reading(1'b1, 190, 1000, 1'b1);
		push_reading(1'b1, 321, 500, 1'b1);
		push_reading(1'b1, 351, 500, 1'b1);
		push_reading(1'b1, 350, 500, 1'b1);
		push_reading(1'b1, 360, 500, 1'b1);
		push_reading(1'b1, 310, 500, 1'b1);
		// Failed flag, both range checks on both sides, and raw field extremes.
		push_reading(1'b0, 250, 500, 1'b1);
		push_reading(1'b1, -401, 500, 1'b1);
		push_reading(1'b1, 1251, 500, 1'b1);
		push_reading(1'b1, 250, -1, 1'b1);
		push_reading(1'b1, 250, 1001, 1'b1);
		push_reading(1'b1, 2047, -2048, 1'b1);
		push_reading(1'b0, -2048, 2047, 1'b1);
		// Out of error on the plausible extremes, then error entered while the alarm is latched.
		push_reading(1'b1, -400, 0, 1'b1);
		push_reading(1'b1, 1250, 1000, 1'b1);
		push_reading(1'b1, 1250, 1000, 1'b1);
		push_reading(1'b0, 1250, 500, 1'b1);
		push_reading(1'b0, 1250, 500, 1'b1);
		push_reading(1'b0, 1250, 500, 1'b1);
		push_reading(1'b1, 1250, 500, 1'b1);
		push_reading(1'b1, 1250, 500, 1'b1);
		// Leave the bus reset phase part way so the lower limit below catches it.
		push_reading(1'b0, 250, 500, 1'b1);
		push_reading(1'b0, 250, 500, 1'b1);

		for (p = 0; p < PHASES; p++) begin
			settle();
			load_config(p < 4 ? plan[p] : random_cfg());
			// A zero limit acts as one, and the phase left over is already above it.
			if (p == 0)
				push_reading(1'b0, 250, 500, 1'b0);
			for (i = 0; i < RANDOM_ITEMS / PHASES; i++)
				random_reading(p != 5);
		end

		settle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
